// ----- sv/i2cew_pkg.sv -----
// Shared types and constants for the I2C EEPROM write-and-verify master.
// No dependencies; the APB, engine, outreg and top files import it.
package i2cew_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_VERIFY = 3'd2,
        MODE_PASS   = 3'd3,
        MODE_FAIL   = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_RECOVER   = 4'd1,
        ST_START     = 4'd2,
        ST_NEXT_BYTE = 4'd3,
        ST_CLK_LOW   = 4'd4,
        ST_BIT_SETUP = 4'd5,
        ST_BIT_CLK   = 4'd6,
        ST_BIT_DONE  = 4'd7,
        ST_STOP_A    = 4'd8,
        ST_STOP_B    = 4'd9,
        ST_STOP_C    = 4'd10,
        ST_STOP      = 4'd11,
        ST_RS_A      = 4'd12,
        ST_RS_B      = 4'd13,
        ST_RS_C      = 4'd14,
        ST_RS        = 4'd15
    } step_t;

    // Result of one transaction on the input channel
    typedef struct packed {
        logic  scl;
        logic  sda;
        mode_t status;
        logic  busy;
    } result_t;

    localparam logic [6:0] DEV_ADDR        = 7'h50;
    localparam logic [6:0] PHASE_LAST      = 7'd99;
    localparam logic [6:0] PHASE_RETRY     = 7'd100;
    localparam logic [3:0] BITS_PER_FRAME  = 4'd9;
    localparam logic [8:0] COUNT_CAP       = 9'd256;
    localparam logic [8:0] COUNT_RESET     = 9'd128;
    localparam logic       REG_BYTE_COUNT  = 1'b0;

endpackage

// ----- sv/i2cew_if.sv -----
// Handshake channels of the I2C EEPROM write-and-verify master.
// Input items and result items; no dependencies.
interface i2cew_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] load_address;
    logic [7:0] load_data;
    logic       sda_in;

    modport source (output valid, output operation, output load_address,
                    output load_data, output sda_in, input ready);
    modport sink   (input valid, input operation, input load_address,
                    input load_data, input sda_in, output ready);
endinterface

interface i2cew_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic [2:0] status;
    logic       busy_res;

    modport source (output valid, output scl_out, output sda_out,
                    output status, output busy_res, input ready);
    modport sink   (input valid, input scl_out, input sda_out,
                    input status, input busy_res, output ready);
endinterface

// ----- sv/i2cew_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the EEPROM image.
module i2cew_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/i2cew_apb.sv -----
// APB-style configuration register block: holds byte_count.
// Depends on i2cew_pkg.
module i2cew_apb (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [8:0]  byte_count
);
    import i2cew_pkg::*;

    logic [8:0] count_reg;
    logic [8:0] count_next;
    logic       hit;

    assign hit    = paddr[2] == REG_BYTE_COUNT;
    assign pready = 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && hit)
        begin
            count_next = pwdata[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prdata     = hit ? {23'd0, count_reg} : 32'd0;
    assign byte_count = count_reg;

endmodule

// ----- sv/i2cew_engine.sv -----
// Bus sequencer: applies one transaction per cycle, while one is accepted, to the
// job state and drives the image RAM ports. Depends on i2cew_pkg.
module i2cew_engine #(
    parameter int IMAGE_DEPTH    = 256,
    parameter int RECOVERY_EDGES = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [1:0]                     operation,
    input  logic [7:0]                     load_address,
    input  logic [7:0]                     load_data,
    input  logic                           sda_in,
    input  logic [8:0]                     byte_count,
    output logic                           mem_we,
    output logic [$clog2(IMAGE_DEPTH)-1:0] mem_waddr,
    output logic [7:0]                     mem_wdata,
    output logic [$clog2(IMAGE_DEPTH)-1:0] mem_raddr,
    input  logic [7:0]                     mem_rdata,
    output i2cew_pkg::result_t             result
);
    import i2cew_pkg::*;

    localparam int IDX_W = $clog2(IMAGE_DEPTH);

    step_t            step_reg,     step_next;
    mode_t            mode_reg,     mode_next;
    logic [7:0]       shift_reg,    shift_next;
    logic [3:0]       bitcnt_reg,   bitcnt_next;
    logic [6:0]       phase_reg,    phase_next;
    logic [8:0]       ptr_reg,      ptr_next;
    logic [IDX_W-1:0] idx_reg,      idx_next;
    logic             rdphase_reg,  rdphase_next;
    logic             match_reg,    match_next;
    logic             scl_reg,      scl_next;
    logic             sda_reg,      sda_next;
    logic             shpend_reg,   shpend_next;
    logic             cmppend_reg,  cmppend_next;
    logic [7:0]       cmpbyte_reg,  cmpbyte_next;

    logic [7:0]       shift_eff;
    logic             match_eff;
    logic             busy;
    logic [8:0]       limit;
    logic [8:0]       ptr_inc;
    logic [IDX_W-1:0] idx_inc;
    logic [3:0]       bit_dec;

    // RAM data read in the previous cycle resolves any pending load or compare
    assign shift_eff = shpend_reg ? mem_rdata : shift_reg;
    assign match_eff = cmppend_reg ? (match_reg && (mem_rdata == cmpbyte_reg)) : match_reg;

    assign busy    = (mode_reg == MODE_WRITE) || (mode_reg == MODE_VERIFY);
    assign limit   = byte_count[8] ? COUNT_CAP : byte_count;
    assign ptr_inc = ptr_reg + 9'd1;
    assign idx_inc = (idx_reg == IDX_W'(IMAGE_DEPTH - 1)) ? '0 : idx_reg + IDX_W'(1);
    assign bit_dec = bitcnt_reg - 4'd1;

    assign mem_raddr = idx_reg;

    always_comb
    begin
        step_next    = step_reg;
        mode_next    = mode_reg;
        shift_next   = shift_eff;
        bitcnt_next  = bitcnt_reg;
        phase_next   = phase_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        rdphase_next = rdphase_reg;
        match_next   = match_eff;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        shpend_next  = 1'b0;
        cmppend_next = 1'b0;
        cmpbyte_next = cmpbyte_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = shift_eff;

        if (accept)
        begin
            case (operation)
                OP_LOAD:
                begin
                    if ({1'b0, load_address} < 9'(IMAGE_DEPTH))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = load_address[IDX_W-1:0];
                        mem_wdata = load_data;
                    end
                end
                OP_START:
                begin
                    if (!busy)
                    begin
                        mode_next = MODE_WRITE;
                        step_next = ST_IDLE;
                    end
                end
                OP_TICK:
                begin
                    if (busy)
                    begin
                        case (step_reg)
                            ST_RECOVER:
                            begin
                                sda_next = 1'b1;
                                if (bitcnt_reg != 4'd0)
                                begin
                                    bitcnt_next = bit_dec;
                                    scl_next    = !scl_reg;
                                end
                                if ((bitcnt_reg == 4'd0) || (bit_dec == 4'd0))
                                begin
                                    step_next = ST_START;
                                end
                            end
                            ST_START:
                            begin
                                sda_next   = 1'b0;
                                phase_next = 7'd0;
                                step_next  = ST_NEXT_BYTE;
                            end
                            ST_NEXT_BYTE:
                            begin
                                rdphase_next = 1'b0;
                                phase_next   = phase_reg + 7'd1;
                                case (phase_reg)
                                    7'd0: shift_next = {DEV_ADDR, 1'b0};
                                    7'd1: shift_next = ptr_reg[7:0];
                                    7'd2:
                                    begin
                                        if (mode_reg == MODE_WRITE)
                                        begin
                                            // image byte arrives from the RAM next cycle
                                            shpend_next = 1'b1;
                                            ptr_next    = ptr_inc;
                                            idx_next    = idx_inc;
                                            phase_next  = PHASE_LAST;
                                        end
                                        else
                                        begin
                                            shift_next = {DEV_ADDR, 1'b1};
                                        end
                                    end
                                    7'd3:
                                    begin
                                        rdphase_next = 1'b1;
                                        phase_next   = PHASE_LAST;
                                    end
                                    default: ;
                                endcase
                                bitcnt_next = BITS_PER_FRAME;
                                scl_next    = 1'b0;
                                if (rdphase_next)
                                begin
                                    sda_next = 1'b1;
                                end
                                step_next = ST_BIT_SETUP;
                            end
                            ST_CLK_LOW:
                            begin
                                scl_next = 1'b0;
                                if (rdphase_reg)
                                begin
                                    sda_next = 1'b1;
                                end
                                step_next = ST_BIT_SETUP;
                            end
                            ST_BIT_SETUP:
                            begin
                                bitcnt_next = bit_dec;
                                sda_next    = rdphase_reg ? 1'b1 : shift_eff[7];
                                if (!rdphase_reg || (bit_dec != 4'd0))
                                begin
                                    shift_next = {shift_eff[6:0], !rdphase_reg};
                                end
                                step_next = ST_BIT_CLK;
                            end
                            ST_BIT_CLK:
                            begin
                                scl_next = 1'b1;
                                if ((bitcnt_reg != 4'd0) && rdphase_reg && sda_in)
                                begin
                                    shift_next = {shift_eff[7:1], 1'b1};
                                end
                                if (bitcnt_reg == 4'd0)
                                begin
                                    if (!rdphase_reg)
                                    begin
                                        if (sda_in)
                                        begin
                                            phase_next = PHASE_RETRY;
                                        end
                                    end
                                    else
                                    begin
                                        // write back the byte read; compare old contents next cycle
                                        mem_we       = 1'b1;
                                        mem_waddr    = idx_reg;
                                        mem_wdata    = shift_eff;
                                        cmppend_next = 1'b1;
                                        cmpbyte_next = shift_eff;
                                        ptr_next     = ptr_inc;
                                        idx_next     = idx_inc;
                                    end
                                end
                                step_next = ST_BIT_DONE;
                            end
                            ST_BIT_DONE:
                            begin
                                if (bitcnt_reg != 4'd0)
                                begin
                                    step_next = ST_CLK_LOW;
                                end
                                else if ((mode_reg == MODE_VERIFY) && (phase_reg == 7'd2))
                                begin
                                    step_next = ST_RS_A;
                                end
                                else if (phase_reg < PHASE_LAST)
                                begin
                                    step_next = ST_NEXT_BYTE;
                                end
                                else if (phase_reg == PHASE_RETRY)
                                begin
                                    step_next = ST_RECOVER;
                                end
                                else
                                begin
                                    step_next = ST_STOP_A;
                                end
                            end
                            ST_STOP_A:
                            begin
                                scl_next  = 1'b0;
                                step_next = ST_STOP_B;
                            end
                            ST_STOP_B:
                            begin
                                sda_next  = 1'b0;
                                step_next = ST_STOP_C;
                            end
                            ST_STOP_C:
                            begin
                                scl_next  = 1'b1;
                                step_next = ST_STOP;
                            end
                            ST_STOP:
                            begin
                                sda_next = 1'b1;
                                if (ptr_reg < limit)
                                begin
                                    step_next = ST_RECOVER;
                                end
                                else
                                begin
                                    if (mode_reg == MODE_WRITE)
                                    begin
                                        mode_next  = MODE_VERIFY;
                                        match_next = 1'b1;
                                    end
                                    else
                                    begin
                                        mode_next = match_eff ? MODE_PASS : MODE_FAIL;
                                    end
                                    step_next = ST_IDLE;
                                end
                            end
                            ST_RS_A:
                            begin
                                scl_next  = 1'b0;
                                step_next = ST_RS_B;
                            end
                            ST_RS_B:
                            begin
                                sda_next  = 1'b1;
                                step_next = ST_RS_C;
                            end
                            ST_RS_C:
                            begin
                                scl_next  = 1'b1;
                                step_next = ST_RS;
                            end
                            ST_RS:
                            begin
                                sda_next  = 1'b0;
                                step_next = ST_NEXT_BYTE;
                            end
                            default:
                            begin
                                // idle step: release the bus and arm the recovery burst
                                scl_next    = 1'b1;
                                sda_next    = 1'b1;
                                step_next   = ST_RECOVER;
                                ptr_next    = 9'd0;
                                idx_next    = '0;
                                bitcnt_next = 4'(RECOVERY_EDGES);
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_IDLE;
            mode_reg    <= MODE_IDLE;
            shift_reg   <= 8'd0;
            bitcnt_reg  <= 4'd0;
            phase_reg   <= 7'd0;
            ptr_reg     <= 9'd0;
            idx_reg     <= '0;
            rdphase_reg <= 1'b0;
            match_reg   <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            shpend_reg  <= 1'b0;
            cmppend_reg <= 1'b0;
            cmpbyte_reg <= 8'd0;
        end
        else
        begin
            step_reg    <= step_next;
            mode_reg    <= mode_next;
            shift_reg   <= shift_next;
            bitcnt_reg  <= bitcnt_next;
            phase_reg   <= phase_next;
            ptr_reg     <= ptr_next;
            idx_reg     <= idx_next;
            rdphase_reg <= rdphase_next;
            match_reg   <= match_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            shpend_reg  <= shpend_next;
            cmppend_reg <= cmppend_next;
            cmpbyte_reg <= cmpbyte_next;
        end
    end

    assign result.scl    = scl_next;
    assign result.sda    = sda_next;
    assign result.status = mode_next;
    assign result.busy   = (mode_next == MODE_WRITE) || (mode_next == MODE_VERIFY);

endmodule

// ----- sv/i2cew_top_note.sv -----
// Result register stage: holds one result transaction until it is taken.
// Depends on i2cew_pkg.
module i2cew_outreg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  i2cew_pkg::result_t res,
    output logic               out_valid,
    input  logic               out_ready,
    output i2cew_pkg::result_t out_res
);
    import i2cew_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- sv/i2c_eeprom_write_verify_master.sv -----
// Top level of the bit-banged I2C EEPROM write-and-verify master.
// Depends on i2cew_pkg, the channel interfaces, i2cew_ram, i2cew_apb,
// i2cew_engine and i2cew_outreg.
//
// Usage:
//   in_ch carries load, start and tick transactions; out_ch returns one
//   result transaction (scl_out, sda_out, status, busy_res) for each.
//   Load the image first, write byte_count over APB (address 0) while idle,
//   send a start, then one tick per bus step with the sampled SDA level.
//   Drive SCL and SDA open-drain from scl_out and sda_out.
// Timing:
//   One transaction per cycle while in_ch.ready is high; the result appears
//   in the cycle after accept. Image bytes come from a single-port-read RAM
//   whose data lands in the next cycle and is forwarded into the next step;
//   a verify compare completes in the cycle after its write-back.
// Reset:
//   Control state clears at once, both lines released, status idle. The
//   image RAM is not cleared; load every byte the job will touch.
// Back-pressure:
//   A result register holds a stalled result; in_ch.ready drops only while
//   that register is full and out_ch.ready is low.
module i2c_eeprom_write_verify_master #(
    parameter int IMAGE_DEPTH    = 256,
    parameter int RECOVERY_EDGES = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cew_in_if.sink    in_ch,
    i2cew_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cew_pkg::*;

    localparam int IDX_W = $clog2(IMAGE_DEPTH);

    logic [8:0]       byte_count;
    logic             accept;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;
    result_t          res;
    result_t          out_res;

    assign accept = in_ch.valid && in_ch.ready;

    i2cew_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_count (byte_count)
    );

    i2cew_ram #(
        .WIDTH (8),
        .DEPTH (IMAGE_DEPTH)
    ) u_image (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    i2cew_engine #(
        .IMAGE_DEPTH    (IMAGE_DEPTH),
        .RECOVERY_EDGES (RECOVERY_EDGES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (in_ch.operation),
        .load_address (in_ch.load_address),
        .load_data    (in_ch.load_data),
        .sda_in       (in_ch.sda_in),
        .byte_count   (byte_count),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .result       (res)
    );

    i2cew_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .res       (res),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_res)
    );

    assign out_ch.scl_out  = out_res.scl;
    assign out_ch.sda_out  = out_res.sda;
    assign out_ch.status   = out_res.status;
    assign out_ch.busy_res = out_res.busy;

endmodule
